// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects signals named clk and rst
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked outside reset.
`define CTF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== src/ctf_pkg.sv =====
package ctf_pkg;

  // Attribute window size in bytes and the matching limit in entries.
  localparam int unsigned WINDOW_BYTES   = 65536;
  localparam logic [16:0] WINDOW_ENTRIES = 17'(WINDOW_BYTES / 2);

  // Tuple id that terminates the chain.
  localparam logic [7:0] END_ID = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [7:0] WANTED_ID_RESET = 8'd0;
  localparam logic [9:0] MAX_LEN_RESET   = 10'd257;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WANTED_ID = 2'd0,
    CFG_MAX_LEN   = 2'd1
  } ctf_cfg_idx_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] attr_byte;
    logic       scan_start;
  } ctf_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    logic       found;
    logic [9:0] copied_count;
  } ctf_out_t;

endpackage

// ===== src/cis_tuple_finder_core.sv =====
// Tuple chain search over card attribute memory.
// Input channel (in_valid/in_ready/in_data): one even-address attribute byte per
// transaction; scan_start marks offset zero and restarts any scan in progress.
// Output channel (out_valid/out_ready/out_data): the copied bytes of the first tuple
// whose id matches wanted_tuple_id, header included, up to max_copy_len of them; the
// final result of a scan has last set and carries found and copied_count.
// A scan that hits the end id or a tuple start past the window gives one
// not-found result.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready.
// Results are registered: a result appears on the output in the cycle after its input byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the next chain walk state is computed
// combinationally between the input handshake and the output register.
// Bytes that give no result are absorbed with no output transaction.
// Reset: the block idles, ignoring bytes until one with scan_start arrives; the
// configuration returns to id 0 and a maximum of 257 bytes.
// Stall: while a result waits in the output register and out_ready is low,
// in_ready drops; it stays high when the waiting result is taken in the same cycle.
module cis_tuple_finder_core
  import ctf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ctf_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ctf_out_t               out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  // Configuration registers.
  logic [7:0]  wanted_tuple_id;
  logic [9:0]  max_copy_len;

  // Chain walk state.
  logic [15:0] entry_pos;
  logic [15:0] tuple_start;
  logic        in_match;
  logic [9:0]  copy_limit;
  logic [9:0]  copy_count;
  logic        scan_done;

  // State after the restart mux, and next state.
  logic [15:0] pos_cur;
  logic [15:0] start_cur;
  logic        match_cur;
  logic [9:0]  limit_cur;
  logic [9:0]  count_cur;
  logic        done_cur;

  logic [15:0] entry_pos_next;
  logic [15:0] tuple_start_next;
  logic        in_match_next;
  logic [9:0]  copy_limit_next;
  logic [9:0]  copy_count_next;
  logic        scan_done_next;

  logic        res_valid;
  ctf_out_t    res;

  logic        accept;
  logic        at_link;
  logic        at_start;
  logic [9:0]  link_len;
  logic [9:0]  count_inc;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_tuple_id <= WANTED_ID_RESET;
      max_copy_len    <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WANTED_ID: wanted_tuple_id <= cfg_data[7:0];
        CFG_MAX_LEN:   max_copy_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A scan start clears the walk state before the byte is looked at.
  always_comb begin
    if (in_data.scan_start) begin
      pos_cur   = '0;
      start_cur = '0;
      match_cur = 1'b0;
      limit_cur = '0;
      count_cur = '0;
      done_cur  = 1'b0;
    end else begin
      pos_cur   = entry_pos;
      start_cur = tuple_start;
      match_cur = in_match;
      limit_cur = copy_limit;
      count_cur = copy_count;
      done_cur  = scan_done;
    end
  end

  // Position tests; the link test is done one bit wider so that a start at the top never matches a link.
  assign at_start  = (pos_cur == start_cur);
  assign at_link   = ({1'b0, pos_cur} == ({1'b0, start_cur} + 17'd1));
  assign link_len  = {2'b00, in_data.attr_byte} + 10'd2;
  assign count_inc = count_cur + 10'd1;

  // Walk the tuple chain for one byte.
  always_comb begin
    entry_pos_next   = pos_cur;
    tuple_start_next = start_cur;
    in_match_next    = match_cur;
    copy_limit_next  = limit_cur;
    copy_count_next  = count_cur;
    scan_done_next   = done_cur;
    res_valid        = 1'b0;
    res              = '0;

    if (!done_cur) begin
      if (match_cur) begin
        // Copying the matching tuple; its link byte may shorten the copy.
        if (at_link && (link_len < limit_cur)) begin
          copy_limit_next = link_len;
        end
        copy_count_next = count_inc;
        res_valid       = 1'b1;
        res.data_byte   = in_data.attr_byte;
        res.data_valid  = 1'b1;
        if (count_inc >= copy_limit_next) begin
          res.last       = 1'b1;
          res.found      = 1'b1;
          res.copied_count = count_inc;
          scan_done_next = 1'b1;
          in_match_next  = 1'b0;
        end
      end else if (at_start) begin
        if (({1'b0, start_cur} >= WINDOW_ENTRIES) || (in_data.attr_byte == END_ID)) begin
          // End of chain or past the window: not found.
          res_valid      = 1'b1;
          res.last       = 1'b1;
          scan_done_next = 1'b1;
        end else if (in_data.attr_byte == wanted_tuple_id) begin
          copy_limit_next = max_copy_len;
          res_valid       = 1'b1;
          if (max_copy_len == 10'd0) begin
            res.last       = 1'b1;
            res.found      = 1'b1;
            scan_done_next = 1'b1;
          end else begin
            copy_count_next = 10'd1;
            res.data_byte   = in_data.attr_byte;
            res.data_valid  = 1'b1;
            if (max_copy_len == 10'd1) begin
              res.last         = 1'b1;
              res.found        = 1'b1;
              res.copied_count = 10'd1;
              scan_done_next   = 1'b1;
            end else begin
              in_match_next = 1'b1;
            end
          end
        end
      end else if (at_link) begin
        // Link byte of a skipped tuple: step to the next tuple start.
        tuple_start_next = start_cur + {8'h00, in_data.attr_byte} + 16'd2;
      end

      if (pos_cur != 16'hFFFF) begin
        entry_pos_next = pos_cur + 16'd1;
      end
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pos   <= '0;
      tuple_start <= '0;
      in_match    <= 1'b0;
      copy_limit  <= '0;
      copy_count  <= '0;
      scan_done   <= 1'b1;
    end else if (accept) begin
      entry_pos   <= entry_pos_next;
      tuple_start <= tuple_start_next;
      in_match    <= in_match_next;
      copy_limit  <= copy_limit_next;
      copy_count  <= copy_count_next;
      scan_done   <= scan_done_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

  // A waiting result is never overwritten by a new transaction.
  `CTF_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready, !in_ready)
  // A result with found set always closes the scan.
  `CTF_ASSERT_IMP(a_found_is_last, out_valid && out_data.found, out_data.last)
  // A result without a byte is always the final one.
  `CTF_ASSERT_IMP(a_empty_is_last, out_valid && !out_data.data_valid, out_data.last)
  // While copying, the count stays below the limit and the scan is open.
  `CTF_ASSERT_IMP(a_copy_bounds, in_match, (copy_count < copy_limit) && !scan_done)
  // Delivering the final result leaves the block idle.
  `CTF_ASSERT_NXT(a_last_closes, accept && res_valid && res.last, scan_done && !in_match)

endmodule
